// ===== rtl/bitmap_frame_allocator_top_macros.svh =====
// Assertion macros used by the allocator datapath.
`ifndef BITMAP_FRAME_ALLOCATOR_TOP_MACROS_SVH
`define BITMAP_FRAME_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication.
`define BFA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define BFA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/bfa_pkg.sv =====
package bfa_pkg;

   localparam int FRAME_COUNT = 4096;
   localparam int FRAME_BYTES = 4096;
   localparam int WORD_BITS   = 32;
   localparam int WORDS       = FRAME_COUNT / WORD_BITS;
   localparam int WORD_AW     = $clog2(WORDS);
   localparam int WCNT_W      = WORD_AW + 1;
   localparam int BIT_W       = $clog2(WORD_BITS);
   localparam int FRAME_W     = $clog2(FRAME_COUNT);
   localparam int CNT_W       = 13;
   localparam int ADDR_W      = 24;
   localparam int OFFS_W      = $clog2(FRAME_BYTES);
   localparam int PC_W        = BIT_W + 1;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } opcode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_RC_RD,
      ST_RC_ACC,
      ST_AL_RD,
      ST_AL_WORD,
      ST_AL_BIT,
      ST_MK_RD,
      ST_MK_WR,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic accept;
      logic rd;
      logic rc_acc;
      logic scan_word;
      logic scan_bit;
      logic mark_wr;
      logic ld_rsp;
   } cmd_type;

   typedef struct packed {
      logic op_free;
      logic alloc_ok;
      logic free_empty;
      logic scan_end;
      logic word_ones;
      logic word_zeros;
      logic word_fit;
      logic bit_found;
      logic bit_last;
      logic mark_last;
      logic rsp_free;
   } status_type;

   // Bits of word w that lie below frame limit t.
   function automatic logic [WORD_BITS-1:0] lim_mask(logic [WCNT_W-1:0] w,
                                                     logic [CNT_W-1:0] t);
      logic [WCNT_W-1:0] tw;
      logic [WORD_BITS-1:0] m;
      tw = t[CNT_W-1:BIT_W];
      if (w < tw) begin
         m = '1;
      end else if (w == tw) begin
         m = ~({WORD_BITS{1'b1}} << t[BIT_W-1:0]);
      end else begin
         m = '0;
      end
      return m;
   endfunction

endpackage

// ===== rtl/bfa_ctrl.sv =====
module bfa_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                csr_wr_en,
   input  bfa_pkg::status_type st,
   output bfa_pkg::cmd_type    cmd
);

   bfa_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bfa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bfa_pkg::ST_IDLE: begin
            if (csr_wr_en) begin
               state_in = bfa_pkg::ST_RC_RD;
            end else if (req_tvalid) begin
               state_in = bfa_pkg::ST_CHECK;
            end
         end
         bfa_pkg::ST_CHECK: begin
            if (st.op_free) begin
               state_in = st.free_empty ? bfa_pkg::ST_RESP : bfa_pkg::ST_MK_RD;
            end else begin
               state_in = st.alloc_ok ? bfa_pkg::ST_AL_RD : bfa_pkg::ST_RESP;
            end
         end
         bfa_pkg::ST_RC_RD: begin
            state_in = st.scan_end ? bfa_pkg::ST_IDLE : bfa_pkg::ST_RC_ACC;
         end
         bfa_pkg::ST_RC_ACC: state_in = bfa_pkg::ST_RC_RD;
         bfa_pkg::ST_AL_RD: begin
            state_in = st.scan_end ? bfa_pkg::ST_RESP : bfa_pkg::ST_AL_WORD;
         end
         bfa_pkg::ST_AL_WORD: begin
            if (st.word_ones) begin
               state_in = bfa_pkg::ST_AL_RD;
            end else if (st.word_zeros) begin
               state_in = st.word_fit ? bfa_pkg::ST_MK_RD : bfa_pkg::ST_AL_RD;
            end else begin
               state_in = bfa_pkg::ST_AL_BIT;
            end
         end
         bfa_pkg::ST_AL_BIT: begin
            if (st.bit_found) begin
               state_in = bfa_pkg::ST_MK_RD;
            end else if (st.bit_last) begin
               state_in = bfa_pkg::ST_AL_RD;
            end
         end
         bfa_pkg::ST_MK_RD: state_in = bfa_pkg::ST_MK_WR;
         bfa_pkg::ST_MK_WR: begin
            state_in = st.mark_last ? bfa_pkg::ST_RESP : bfa_pkg::ST_MK_RD;
         end
         bfa_pkg::ST_RESP: begin
            if (st.rsp_free) begin
               state_in = bfa_pkg::ST_IDLE;
            end
         end
         default: state_in = bfa_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         bfa_pkg::ST_IDLE: begin
            req_tready = !csr_wr_en;
            cmd.accept = req_tvalid && !csr_wr_en;
         end
         bfa_pkg::ST_RC_RD:   cmd.rd = !st.scan_end;
         bfa_pkg::ST_RC_ACC:  cmd.rc_acc = 1'b1;
         bfa_pkg::ST_AL_RD:   cmd.rd = !st.scan_end;
         bfa_pkg::ST_AL_WORD: cmd.scan_word = 1'b1;
         bfa_pkg::ST_AL_BIT:  cmd.scan_bit = 1'b1;
         bfa_pkg::ST_MK_RD:   cmd.rd = 1'b1;
         bfa_pkg::ST_MK_WR:   cmd.mark_wr = 1'b1;
         bfa_pkg::ST_RESP:    cmd.ld_rsp = st.rsp_free;
         default: cmd = '0;
      endcase
   end

endmodule

// ===== rtl/bfa_dpath.sv =====
`include "bitmap_frame_allocator_top_macros.svh"

module bfa_dpath (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [bfa_pkg::CNT_W-1:0]    csr_wr_data,
   input  logic                         req_op,
   input  logic [bfa_pkg::ADDR_W-1:0]   req_addr,
   input  logic [bfa_pkg::CNT_W-1:0]    req_len,
   input  bfa_pkg::cmd_type             cmd,
   output bfa_pkg::status_type          st,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [bfa_pkg::ADDR_W-1:0]   rsp_addr,
   output logic                         rsp_status,
   output logic [bfa_pkg::CNT_W-1:0]    rsp_free
);

   logic [bfa_pkg::WORD_BITS-1:0] bitmap_mem [bfa_pkg::WORDS];
   logic [bfa_pkg::WORD_BITS-1:0] mem_q_ff;
   logic          vld_q_ff;
   logic [bfa_pkg::WORDS-1:0] vld_ff, vld_in;

   logic [bfa_pkg::CNT_W-1:0]   total_ff, total_in;
   logic [bfa_pkg::CNT_W-1:0]   free_ff, free_in;
   logic [bfa_pkg::WCNT_W-1:0]  w_ff, w_in;
   logic [bfa_pkg::BIT_W-1:0]   bit_ff, bit_in;
   logic [bfa_pkg::CNT_W-1:0]   run_ff, run_in;
   logic [bfa_pkg::FRAME_W-1:0] start_ff, start_in;
   logic [bfa_pkg::FRAME_W-1:0] a_ff, a_in;
   logic [bfa_pkg::CNT_W-1:0]   b_ff, b_in;
   logic [bfa_pkg::CNT_W-1:0]   len_ff, len_in;
   logic                        op_ff, op_in;
   logic                        found_ff, found_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [bfa_pkg::ADDR_W-1:0]  rsp_addr_ff, rsp_addr_in;
   logic                        rsp_status_ff, rsp_status_in;
   logic [bfa_pkg::CNT_W-1:0]   rsp_free_ff, rsp_free_in;

   logic [bfa_pkg::WORD_BITS-1:0] data, eff, range_m, new_word;
   logic [bfa_pkg::CNT_W-1:0]   w_base;
   logic [bfa_pkg::FRAME_W-1:0] frame, cur_start, base;
   logic [bfa_pkg::CNT_W:0]     free_end;
   logic [bfa_pkg::PC_W-1:0]    pc_free, pc_freed;
   logic                        word_ones, word_zeros, word_fit, bit_found;

   assign data     = vld_q_ff ? mem_q_ff : '1;
   assign eff      = data | ~bfa_pkg::lim_mask(w_ff, total_ff);
   assign range_m  = bfa_pkg::lim_mask(w_ff, b_ff)
                   & ~bfa_pkg::lim_mask(w_ff, bfa_pkg::CNT_W'(a_ff));
   assign new_word = (op_ff == bfa_pkg::OP_FREE) ? (data & ~range_m) : (data | range_m);
   assign w_base   = bfa_pkg::CNT_W'({w_ff, bfa_pkg::BIT_W'(0)});
   assign frame    = {w_ff[bfa_pkg::WORD_AW-1:0], bit_ff};
   assign cur_start = (run_ff == '0) ? frame : start_ff;
   assign base     = bfa_pkg::FRAME_W'(req_addr[bfa_pkg::ADDR_W-1:bfa_pkg::OFFS_W]);
   assign free_end = (bfa_pkg::CNT_W+1)'(base) + (bfa_pkg::CNT_W+1)'(req_len);
   assign pc_free  = bfa_pkg::PC_W'($countones(~eff));
   assign pc_freed = bfa_pkg::PC_W'($countones(data & range_m));

   assign word_ones  = (eff == '1);
   assign word_zeros = (eff == '0);
   assign word_fit   = ((bfa_pkg::CNT_W+1)'(run_ff)
                       + (bfa_pkg::CNT_W+1)'(bfa_pkg::WORD_BITS))
                       >= (bfa_pkg::CNT_W+1)'(len_ff);
   assign bit_found  = !eff[bit_ff] && ((run_ff + 1'b1) == len_ff);

   always_comb begin
      st.op_free    = (op_ff == bfa_pkg::OP_FREE);
      st.alloc_ok   = (len_ff != '0) && (free_ff != '0) && (len_ff <= total_ff);
      st.free_empty = (b_ff <= bfa_pkg::CNT_W'(a_ff));
      st.scan_end   = (w_base >= total_ff);
      st.word_ones  = word_ones;
      st.word_zeros = word_zeros;
      st.word_fit   = word_fit;
      st.bit_found  = bit_found;
      st.bit_last   = (bit_ff == '1);
      st.mark_last  = ((w_base + bfa_pkg::CNT_W'(bfa_pkg::WORD_BITS)) >= b_ff);
      st.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      total_in = total_ff;
      free_in  = free_ff;
      w_in     = w_ff;
      bit_in   = bit_ff;
      run_in   = run_ff;
      start_in = start_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      len_in   = len_ff;
      op_in    = op_ff;
      found_in = found_ff;
      vld_in   = vld_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_free_in   = rsp_free_ff;

      if (csr_wr_en) begin
         total_in = (csr_wr_data > bfa_pkg::CNT_W'(bfa_pkg::FRAME_COUNT))
                  ? bfa_pkg::CNT_W'(bfa_pkg::FRAME_COUNT) : csr_wr_data;
         free_in  = '0;
         w_in     = '0;
      end

      if (cmd.accept) begin
         op_in    = req_op;
         len_in   = req_len;
         run_in   = '0;
         bit_in   = '0;
         found_in = 1'b0;
         if (req_op == bfa_pkg::OP_FREE) begin
            a_in = base;
            b_in = (free_end > (bfa_pkg::CNT_W+1)'(total_ff))
                 ? total_ff : bfa_pkg::CNT_W'(free_end);
            w_in = bfa_pkg::WCNT_W'(base[bfa_pkg::FRAME_W-1:bfa_pkg::BIT_W]);
         end else begin
            w_in = '0;
         end
      end

      if (cmd.rc_acc) begin
         free_in = free_ff + bfa_pkg::CNT_W'(pc_free);
         w_in    = w_ff + 1'b1;
      end

      if (cmd.scan_word) begin
         if (word_ones) begin
            run_in = '0;
            w_in   = w_ff + 1'b1;
         end else if (word_zeros) begin
            if (word_fit) begin
               found_in = 1'b1;
               a_in     = cur_start;
               b_in     = bfa_pkg::CNT_W'(cur_start) + len_ff;
               free_in  = free_ff - len_ff;
               w_in     = bfa_pkg::WCNT_W'(cur_start[bfa_pkg::FRAME_W-1:bfa_pkg::BIT_W]);
            end else begin
               start_in = cur_start;
               run_in   = run_ff + bfa_pkg::CNT_W'(bfa_pkg::WORD_BITS);
               w_in     = w_ff + 1'b1;
            end
         end
      end

      if (cmd.scan_bit) begin
         if (eff[bit_ff]) begin
            run_in = '0;
         end else if (bit_found) begin
            found_in = 1'b1;
            a_in     = cur_start;
            b_in     = bfa_pkg::CNT_W'(cur_start) + len_ff;
            free_in  = free_ff - len_ff;
            w_in     = bfa_pkg::WCNT_W'(cur_start[bfa_pkg::FRAME_W-1:bfa_pkg::BIT_W]);
         end else begin
            start_in = cur_start;
            run_in   = run_ff + 1'b1;
         end
         if (!bit_found) begin
            bit_in = bit_ff + 1'b1;
            if (bit_ff == '1) begin
               w_in = w_ff + 1'b1;
            end
         end
      end

      if (cmd.mark_wr) begin
         vld_in[w_ff[bfa_pkg::WORD_AW-1:0]] = 1'b1;
         if (op_ff == bfa_pkg::OP_FREE) begin
            free_in = free_ff + bfa_pkg::CNT_W'(pc_freed);
         end
         w_in = w_ff + 1'b1;
      end

      if (cmd.ld_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = (op_ff == bfa_pkg::OP_ALLOC) && !found_ff;
         rsp_addr_in   = ((op_ff == bfa_pkg::OP_ALLOC) && found_ff)
                       ? bfa_pkg::ADDR_W'({a_ff, bfa_pkg::OFFS_W'(0)}) : '0;
         rsp_free_in   = free_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         free_ff      <= '0;
         w_ff         <= '0;
         bit_ff       <= '0;
         run_ff       <= '0;
         found_ff     <= 1'b0;
         op_ff        <= bfa_pkg::OP_ALLOC;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         total_ff     <= total_in;
         free_ff      <= free_in;
         w_ff         <= w_in;
         bit_ff       <= bit_in;
         run_ff       <= run_in;
         found_ff     <= found_in;
         op_ff        <= op_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff      <= start_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      len_ff        <= len_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_free_ff   <= rsp_free_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.mark_wr) begin
         bitmap_mem[w_ff[bfa_pkg::WORD_AW-1:0]] <= new_word;
      end
      if (cmd.rd) begin
         mem_q_ff <= bitmap_mem[w_ff[bfa_pkg::WORD_AW-1:0]];
         vld_q_ff <= vld_ff[w_ff[bfa_pkg::WORD_AW-1:0]];
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_addr   = rsp_addr_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_free   = rsp_free_ff;

   `BFA_ASSERT_IMP(a_free_le_total, clock, reset, 1'b1, free_ff <= total_ff,
                   "free count above total")
   `BFA_ASSERT_IMP(a_fail_addr_zero, clock, reset, rsp_valid_ff && rsp_status_ff,
                   rsp_addr_ff == '0, "failed allocation with address")
   `BFA_ASSERT_IMP(a_alloc_was_free, clock, reset, cmd.mark_wr && op_ff == bfa_pkg::OP_ALLOC,
                   (data & range_m) == '0, "allocated frame was in use")
   `BFA_ASSERT_NXT(a_csr_clears_count, clock, reset, csr_wr_en, free_ff == '0,
                   "recount did not start from zero")

endmodule

// ===== rtl/bitmap_frame_allocator_top.sv =====
// First-fit frame allocator over a 4096-frame used bitmap held in a 128 x 32 memory, all
// frames used after reset (no clearing pass). One transaction is handled at a time; each
// memory word visited takes a registered read, then a process or write-back step. A
// register write recounts free frames over ceil(total/32) words, each read and then
// accumulated, during which no transaction is taken. A free transaction reads and writes
// back each word touched. An allocate reads each word scanned, checks each partly used
// word one frame a cycle, then reads and writes back each word marked. The result waits
// in an output register, so the next transaction may start once it is loaded.
module bitmap_frame_allocator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [12:0] csr_wr_data,     // total_frames
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,       // byte_address[23:0], run_length[36:24], zero pad
   input  logic        req_tuser,       // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata        // run_address[23:0], status[24], free_frames[37:25]
);

   bfa_pkg::cmd_type    cmd;
   bfa_pkg::status_type st;
   logic [bfa_pkg::ADDR_W-1:0] rsp_addr;
   logic                       rsp_status;
   logic [bfa_pkg::CNT_W-1:0]  rsp_free;

   bfa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .csr_wr_en  (csr_wr_en),
      .st         (st),
      .cmd        (cmd)
   );

   bfa_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_op      (req_tuser),
      .req_addr    (req_tdata[23:0]),
      .req_len     (req_tdata[36:24]),
      .cmd         (cmd),
      .st          (st),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_addr    (rsp_addr),
      .rsp_status  (rsp_status),
      .rsp_free    (rsp_free)
   );

   assign rsp_tdata = {2'b00, rsp_free, rsp_status, rsp_addr};

endmodule

// ===== tb/testbench.sv =====
module testbench;

   typedef struct {
      bfa_pkg::opcode_type op;
      logic [23:0] addr;
      logic [12:0] len;
   } frame_req_type;

   typedef struct {
      logic [23:0] run_addr;
      logic        status;
      logic [12:0] free_frames;
   } frame_rsp_type;

   localparam int CYCLE_LIMIT = 30000000;
   localparam int HOLD_CYCLES = 3000;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [12:0] csr_wr_data;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;

   frame_req_type pending_q[$];
   frame_rsp_type expected_q[$];
   frame_req_type offered;
   logic [bfa_pkg::FRAME_COUNT-1:0] used_map;
   logic [12:0] managed_total;
   logic [12:0] free_cnt;
   int send_idle_pct;
   int stall_pct;
   int hold_left;
   bit hold_go;
   bit hold_done;
   bit hold_send;
   int errors;
   int cycles;

   bitmap_frame_allocator_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   function automatic int managed_limit();
      return (managed_total > bfa_pkg::FRAME_COUNT) ? bfa_pkg::FRAME_COUNT
                                                     : int'(managed_total);
   endfunction

   task automatic recount_free();
      int t;
      int n;
      t = managed_limit();
      n = 0;
      for (int f = 0; f < t; f++) begin
         if (!used_map[f]) n++;
      end
      free_cnt = n[12:0];
   endtask

   task automatic allocate_or_free(input frame_req_type it, output frame_rsp_type r);
      int t;
      int run;
      int start;
      int base;
      int f;
      bit found;
      t = managed_limit();
      run = 0;
      start = 0;
      found = 0;
      r.run_addr = '0;
      r.status = 1'b1;
      if (it.op == bfa_pkg::OP_ALLOC) begin
         if (it.len != 0 && free_cnt != 0 && int'(it.len) <= t) begin
            for (f = 0; f < t; f++) begin
               if (used_map[f]) begin
                  run = 0;
               end else begin
                  run++;
                  if (run == int'(it.len)) begin
                     start = f + 1 - int'(it.len);
                     found = 1;
                     break;
                  end
               end
            end
         end
         if (found) begin
            for (int i = 0; i < int'(it.len); i++) begin
               if (!used_map[start + i]) begin
                  used_map[start + i] = 1'b1;
                  free_cnt = free_cnt - 1'b1;
               end
            end
            r.run_addr = 24'(start * bfa_pkg::FRAME_BYTES);
            r.status = 1'b0;
         end
      end else begin
         r.status = 1'b0;
         base = int'(it.addr) / bfa_pkg::FRAME_BYTES;
         for (int i = 0; i < int'(it.len); i++) begin
            f = base + i;
            if (f < t && used_map[f]) begin
               used_map[f] = 1'b0;
               free_cnt = free_cnt + 1'b1;
            end
         end
      end
      r.free_frames = free_cnt;
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      frame_rsp_type r;
      bit busy;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tuser <= 1'b0;
      end else begin
         busy = req_tvalid;
         if (req_tvalid && req_tready) begin
            allocate_or_free(offered, r);
            expected_q.push_back(r);
            busy = 0;
         end
         if (!busy) begin
            if (pending_q.size() > 0 && !hold_send &&
                $urandom_range(99) >= send_idle_pct) begin
               offered = pending_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {3'b0, offered.len, offered.addr};
               req_tuser <= offered.op;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_go && !hold_done) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      frame_rsp_type e;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               $display("%0t: result with none expected, actual %h", $time, rsp_tdata);
               errors++;
            end else begin
               e = expected_q.pop_front();
               if (rsp_tdata[23:0] !== e.run_addr) begin
                  $display("%0t: run_address expected %h actual %h", $time, e.run_addr,
                           rsp_tdata[23:0]);
                  errors++;
               end
               if (rsp_tdata[24] !== e.status) begin
                  $display("%0t: status expected %b actual %b", $time, e.status,
                           rsp_tdata[24]);
                  errors++;
               end
               if (rsp_tdata[37:25] !== e.free_frames) begin
                  $display("%0t: free_frames expected %0d actual %0d", $time,
                           e.free_frames, rsp_tdata[37:25]);
                  errors++;
               end
            end
         end
         rsp_tready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("bitmap_frame_allocator_top regression: fail");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_q.size() > 0 || req_tvalid || expected_q.size() > 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);
   endtask

   task automatic write_total(input logic [12:0] v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      managed_total = v;
      recount_free();
   endtask

   task automatic add_item(input bfa_pkg::opcode_type op, input logic [23:0] addr,
                           input logic [12:0] len);
      frame_req_type it;
      it.op = op;
      it.addr = addr;
      it.len = len;
      pending_q.push_back(it);
   endtask

   task automatic add_random(input int n);
      int t;
      int fr;
      logic [12:0] len;
      for (int k = 0; k < n; k++) begin
         t = managed_limit();
         if ($urandom_range(99) < 5) begin
            len = 13'($urandom);
         end else if ($urandom_range(99) < 10) begin
            len = 13'($urandom_range(64, 600));
         end else begin
            len = 13'($urandom_range(1, 40));
         end
         if ($urandom_range(99) < 55) begin
            add_item(bfa_pkg::OP_ALLOC, 24'($urandom), len);
         end else begin
            fr = (t > 0 && $urandom_range(9) != 0) ? $urandom_range(t + 16) :
                 $urandom_range(bfa_pkg::FRAME_COUNT - 1);
            add_item(bfa_pkg::OP_FREE,
                     24'(fr * bfa_pkg::FRAME_BYTES
                         + $urandom_range(bfa_pkg::FRAME_BYTES - 1)), len);
         end
      end
   endtask

   initial begin
      logic [12:0] totals[6];
      totals = '{13'd4096, 13'd8191, 13'd517, 13'd32, 13'd4095, 13'd1};
      hold_go = 0;
      hold_send = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      used_map = '1;
      managed_total = '0;
      free_cnt = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      add_item(bfa_pkg::OP_ALLOC, 24'h0, 13'd1);
      add_item(bfa_pkg::OP_FREE, 24'h0, 13'd8);
      wait_drained();
      write_total(13'd4096);
      add_item(bfa_pkg::OP_ALLOC, 24'hFFFFFF, 13'd0);
      add_item(bfa_pkg::OP_ALLOC, 24'h0, 13'd1);
      add_item(bfa_pkg::OP_FREE, 24'h000FFF, 13'd4096);
      add_item(bfa_pkg::OP_FREE, 24'h000000, 13'd10);
      add_item(bfa_pkg::OP_ALLOC, 24'h0, 13'd0);
      add_item(bfa_pkg::OP_ALLOC, 24'h0, 13'd4096);
      add_item(bfa_pkg::OP_ALLOC, 24'h0, 13'd1);
      add_item(bfa_pkg::OP_FREE, 24'hFFFFFF, 13'd8191);
      add_item(bfa_pkg::OP_FREE, 24'hFFF000, 13'd1);
      add_item(bfa_pkg::OP_ALLOC, 24'h0, 13'd2);
      add_item(bfa_pkg::OP_ALLOC, 24'h0, 13'd1);
      add_item(bfa_pkg::OP_FREE, 24'h800000, 13'd3000);
      add_item(bfa_pkg::OP_ALLOC, 24'h0, 13'd8191);
      add_item(bfa_pkg::OP_ALLOC, 24'h0, 13'd4097);
      add_item(bfa_pkg::OP_ALLOC, 24'h0, 13'd2048);
      add_item(bfa_pkg::OP_ALLOC, 24'h0, 13'd1000);
      add_item(bfa_pkg::OP_FREE, 24'h555555, 13'd5);
      add_item(bfa_pkg::OP_FREE, 24'hAAAAAA, 13'd5);
      add_item(bfa_pkg::OP_ALLOC, 24'h0, 13'd5);
      wait_drained();

      for (int p = 0; p < 6; p++) begin
         write_total(totals[p]);
         case (p % 4)
            0: begin send_idle_pct = 0; stall_pct = 0; end
            1: begin send_idle_pct = 65; stall_pct = 0; end
            2: begin send_idle_pct = 0; stall_pct = 65; end
            default: begin send_idle_pct = 19; stall_pct = 19; end
         endcase
         add_random(90);
         if (p == 0) hold_go = 1;
         while (pending_q.size() >= 45) @(posedge clock);
         hold_send = 1;
         while (req_tvalid || expected_q.size() > 0) @(posedge clock);
         hold_send = 0;
         add_random(90);
         wait_drained();
      end

      if (errors == 0) begin
         $display("bitmap_frame_allocator_top regression: pass");
      end else begin
         $display("bitmap_frame_allocator_top regression: fail");
      end
      $finish;
   end
endmodule
